// ===== design/rgb_led_bit_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// rgb_led_bit_encoder assertion macros
// Shared concurrent assertion forms; clocked on clk, disabled while rst_n low.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_BIT_ENCODER_ASSERT_SVH
`define RGB_LED_BIT_ENCODER_ASSERT_SVH

// Condition must hold at every clock edge outside reset
`define RLBE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent on one edge implies consequent on the same edge
`define RLBE_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/rlbe_pkg.sv =====
// ----------------------------------------------------------------------------
// rlbe_pkg
// Types and constants shared by the RGB LED bit encoder modules.
// ----------------------------------------------------------------------------
package rlbe_pkg;

    // Brightness register
    localparam int BRIGHT_W = 7;
    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX   = 7'd100;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 7'd20;

    // Symbol bytes
    localparam logic [7:0] SYM_ONE  = 8'h06;
    localparam logic [7:0] SYM_ZERO = 8'h04;

    // One pixel is 24 bits, one symbol per bit
    localparam int PIXEL_BITS = 24;
    localparam int BIT_CNT_W  = $clog2(PIXEL_BITS);

    // Channel times brightness fits in 15 bits (255 * 100)
    localparam int PROD_W = 15;

    // Divide by 100: multiply by ceil(2^19 / 100) and shift right by 19.
    // Exact for every product up to 255 * 100.
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

    typedef logic [PIXEL_BITS-1:0] pixel_word_t;
    typedef logic [PROD_W-1:0]     prod_t;

    // Write request from the front end into the pixel queue
    typedef struct packed {
        logic        push;
        pixel_word_t word;
    } q_wr_t;

    // Scaled channel = product / 100, truncated
    function automatic logic [7:0] div100(input prod_t prod);
        logic [PROD_W+RECIP_W-1:0] t;
        t = {{RECIP_W{1'b0}}, prod} * {{PROD_W{1'b0}}, RECIP_100};
        return t[RECIP_SHIFT+7:RECIP_SHIFT];
    endfunction

endpackage

// ===== design/rlbe_front.sv =====
// ----------------------------------------------------------------------------
// rlbe_front
// Accepts pixels, scales each channel by brightness and packs the GRB word.
// ----------------------------------------------------------------------------
module rlbe_front
    import rlbe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [BRIGHT_W-1:0] cfg_wdata,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          green,
    input  logic [7:0]          red,
    input  logic [7:0]          blue,
    input  logic                q_full,
    output q_wr_t               q_wr
);

    logic [BRIGHT_W-1:0] bright_reg;
    logic [BRIGHT_W-1:0] bright_next;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    prod_t               prod_g_reg, prod_r_reg, prod_b_reg;
    prod_t               prod_g_next, prod_r_next, prod_b_next;
    logic                accept;

    // Brightness register, saturating at 100
    always_comb
    begin
        bright_next = bright_reg;
        if (cfg_we)
        begin
            bright_next = (cfg_wdata > BRIGHT_MAX) ? BRIGHT_MAX : cfg_wdata;
        end
    end

    // Product stage stalls only when holding a word the queue cannot take
    assign full   = s1_valid_reg && q_full;
    assign accept = push && !full;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        prod_g_next   = prod_g_reg;
        prod_r_next   = prod_r_reg;
        prod_b_next   = prod_b_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            prod_g_next   = PROD_W'(green) * PROD_W'(bright_reg);
            prod_r_next   = PROD_W'(red)   * PROD_W'(bright_reg);
            prod_b_next   = PROD_W'(blue)  * PROD_W'(bright_reg);
        end
        else if (!q_full)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg   <= BRIGHT_RESET;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            bright_reg   <= bright_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_g_reg <= prod_g_next;
        prod_r_reg <= prod_r_next;
        prod_b_reg <= prod_b_next;
    end

    // Divide by 100 and pack green, red, blue
    assign q_wr.push = s1_valid_reg && !q_full;
    assign q_wr.word = {div100(prod_g_reg), div100(prod_r_reg), div100(prod_b_reg)};

endmodule

// ===== design/rlbe_fifo.sv =====
// ----------------------------------------------------------------------------
// rlbe_fifo
// Small register queue between the pixel front end and the symbol shifter.
// ----------------------------------------------------------------------------
module rlbe_fifo #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== design/rlbe_back.sv =====
// ----------------------------------------------------------------------------
// rlbe_back
// Shifts each queued pixel word out MSB first as one symbol byte per bit.
// ----------------------------------------------------------------------------
module rlbe_back
    import rlbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  pixel_word_t q_data,
    output logic        q_pop,
    input  logic        pop,
    output logic        empty,
    output logic [7:0]  spi_byte,
    output logic        last
);

    `include "rgb_led_bit_encoder_assert.svh"

    logic [PIXEL_BITS-2:0] word_reg, word_next;
    logic [BIT_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            spi_reg, spi_next;
    logic                  last_reg, last_next;
    logic                  advance;

    // Output register frees up when empty or when its symbol is taken
    assign advance = !out_valid_reg || pop;

    always_comb
    begin
        word_next      = word_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        spi_next       = spi_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;
        if (advance)
        begin
            if (cnt_reg != '0)
            begin
                // Continue the current pixel
                spi_next       = word_reg[PIXEL_BITS-2] ? SYM_ONE : SYM_ZERO;
                last_next      = (cnt_reg == BIT_CNT_W'(1));
                word_next      = {word_reg[PIXEL_BITS-3:0], 1'b0};
                cnt_next       = cnt_reg - 1'b1;
                out_valid_next = 1'b1;
            end
            else if (!q_empty)
            begin
                // Start the next pixel, first bit goes out directly
                q_pop          = 1'b1;
                spi_next       = q_data[PIXEL_BITS-1] ? SYM_ONE : SYM_ZERO;
                last_next      = 1'b0;
                word_next      = q_data[PIXEL_BITS-2:0];
                cnt_next       = BIT_CNT_W'(PIXEL_BITS - 1);
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        spi_reg  <= spi_next;
        last_reg <= last_next;
    end

    assign empty    = !out_valid_reg;
    assign spi_byte = spi_reg;
    assign last     = last_reg;

    // Checks
    `RLBE_ASSERT_ALWAYS(a_cnt_range, cnt_reg <= BIT_CNT_W'(PIXEL_BITS - 1),
        "bit counter beyond pixel length")
    `RLBE_ASSERT_IMPLIES(a_busy_shows, cnt_reg != '0, out_valid_reg,
        "pixel in progress with no symbol shown")
    `RLBE_ASSERT_IMPLIES(a_last_done, out_valid_reg && last_reg, cnt_reg == '0,
        "last symbol shown with bits still pending")
    `RLBE_ASSERT_IMPLIES(a_sym_code, out_valid_reg,
        spi_reg == SYM_ONE || spi_reg == SYM_ZERO, "illegal symbol byte")

endmodule

// ===== design/rgb_led_bit_encoder.sv =====
// ----------------------------------------------------------------------------
// rgb_led_bit_encoder
// Brightness-scaled GRB pixel to 24 SPI symbol bytes, queue-style ports.
// ----------------------------------------------------------------------------
// A pixel passes the product register and queue before its first symbol.
// Throughput: one symbol per cycle while pop is high, set by the
//   back-end shifter that emits one bit of the packed word each cycle.
// Up to QUEUE_DEPTH + 1 pixels wait ahead of the shifter before full rises.
// Reset: brightness returns to 20 percent, all queues and stages empty.
module rgb_led_bit_encoder
    import rlbe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [BRIGHT_W-1:0] cfg_wdata,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          green,
    input  logic [7:0]          red,
    input  logic [7:0]          blue,
    output logic                empty,
    input  logic                pop,
    output logic [7:0]          spi_byte,
    output logic                last
);

    q_wr_t       q_wr;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    pixel_word_t q_data;

    // Front end: brightness scale and packing
    rlbe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .green     (green),
        .red       (red),
        .blue      (blue),
        .q_full    (q_full),
        .q_wr      (q_wr)
    );

    // Pixel word queue
    rlbe_fifo #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr.push),
        .wr_data (q_wr.word),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    // Back end: symbol shifter
    rlbe_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .spi_byte (spi_byte),
        .last     (last)
    );

endmodule

// ===== tb/rgb_led_bit_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// rgb_led_bit_encoder_tb
// Self-checking bench for the pixel to SPI symbol encoder. Pixel requests go
// in through a clocked driver and symbols come out through a clocked monitor.
// Each symbol is checked against a brightness-scaled bit pattern.
// The brightness register is swept over several values, including the
// saturating writes.
// ----------------------------------------------------------------------------
module rgb_led_bit_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rlbe_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned POP_HOLD_LEN   = 400;
    localparam int unsigned POP_HOLD_FIRST = 1500;
    localparam int unsigned POP_HOLD_STEP  = 4000;
    localparam int          RAND_PHASES    = 6;
    localparam int          RAND_PIXELS    = 57;

    typedef struct {
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
    } pixel_t;

    typedef struct {
        logic [7:0] spi_byte;
        logic       last;
    } symbol_t;

    // DUT ports
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [BRIGHT_W-1:0] cfg_wdata = '0;
    logic                push      = 1'b0;
    logic                full;
    logic [7:0]          green     = '0;
    logic [7:0]          red       = '0;
    logic [7:0]          blue      = '0;
    logic                empty;
    logic                pop       = 1'b0;
    logic [7:0]          spi_byte;
    logic                last;

    // Bench state
    pixel_t              pixel_q[$];
    symbol_t             symbol_q[$];
    logic [BRIGHT_W-1:0] bright_pct    = BRIGHT_RESET;
    bit                  px_accepted   = 1'b0;
    bit                  idle_on       = 1'b1;
    int unsigned         send_gap      = 0;
    int unsigned         recv_gap      = 0;
    int unsigned         pop_hold_left = 0;
    int unsigned         pop_hold_mark = POP_HOLD_FIRST;
    int unsigned         symbols_seen  = 0;
    int unsigned         stall_cycles  = 0;
    int unsigned         fail_count    = 0;

    rgb_led_bit_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .push     (push),
        .full     (full),
        .green    (green),
        .red      (red),
        .blue     (blue),
        .empty    (empty),
        .pop      (pop),
        .spi_byte (spi_byte),
        .last     (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Writes above full scale saturate
    function automatic logic [BRIGHT_W-1:0] clamp_brightness(logic [BRIGHT_W-1:0] v);
        return (v > BRIGHT_MAX) ? BRIGHT_MAX : v;
    endfunction

    // channel * percent / 100, truncated
    function automatic logic [7:0] scale_channel(logic [7:0] ch);
        int unsigned prod;
        prod = ch * bright_pct;
        return 8'(prod / BRIGHT_MAX);
    endfunction

    // Pack scaled G, R, B and expand MSB first into symbol bytes
    function automatic void queue_pixel_symbols(pixel_t px);
        logic [PIXEL_BITS-1:0] word;
        symbol_t               sym;
        word = {scale_channel(px.green), scale_channel(px.red), scale_channel(px.blue)};
        for (int k = PIXEL_BITS - 1; k >= 0; k--)
        begin
            sym.spi_byte = word[k] ? SYM_ONE : SYM_ZERO;
            sym.last     = (k == 0);
            symbol_q.push_back(sym);
        end
    endfunction

    function automatic void add_pixel(logic [7:0] g, logic [7:0] r, logic [7:0] b);
        pixel_t px;
        px.green = g;
        px.red   = r;
        px.blue  = b;
        pixel_q.push_back(px);
    endfunction

    // Random byte biased toward the extremes
    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    // Block is idle: no pending request, nothing in flight
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pixel_q.size() != 0 || push || symbol_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_brightness(logic [BRIGHT_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Pixel request driver
    always @(negedge clk)
    begin : drive_pixels
        pixel_t nxt;
        if (rst_n)
        begin
            if (push && !px_accepted)
            begin
                // hold the request until it is taken
            end
            else if (send_gap == 0 && pixel_q.size() != 0 &&
                     !(idle_on && $urandom_range(0, 5) == 0))
            begin
                nxt = pixel_q.pop_front();
                push  <= 1'b1;
                green <= nxt.green;
                red   <= nxt.red;
                blue  <= nxt.blue;
            end
            else
            begin
                if (send_gap != 0)
                    send_gap--;
                else if (pixel_q.size() != 0)
                    send_gap = $urandom_range(0, 6);
                push  <= 1'b0;
                green <= 8'($urandom());
                red   <= 8'($urandom());
                blue  <= 8'($urandom());
            end
        end
    end

    // Symbol pop driver; long hold-offs let the block fill and stall its input
    always @(negedge clk)
    begin : drive_pop
        if (rst_n)
        begin
            if (pop_hold_left == 0 && symbols_seen >= pop_hold_mark)
            begin
                pop_hold_left = POP_HOLD_LEN;
                pop_hold_mark += POP_HOLD_STEP;
            end
            if (pop_hold_left != 0)
            begin
                pop_hold_left--;
                pop <= 1'b0;
            end
            else if (recv_gap != 0)
            begin
                recv_gap--;
                pop <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(0, 6);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Monitor: track config, predict on accepted requests, check symbols
    always @(posedge clk)
    begin : check_symbols
        symbol_t want;
        if (rst_n)
        begin
            px_accepted = push && !full;
            if (cfg_we)
                bright_pct = clamp_brightness(cfg_wdata);
            if (px_accepted)
                queue_pixel_symbols('{green, red, blue});

            if (pop && !empty)
            begin
                symbols_seen++;
                if (symbol_q.size() == 0)
                begin
                    $error("unexpected symbol: spi_byte %0d last %0d", spi_byte, last);
                    fail_count++;
                end
                else
                begin
                    want = symbol_q.pop_front();
                    if (spi_byte !== want.spi_byte)
                    begin
                        $error("spi_byte mismatch: expected %0d, actual %0d",
                               want.spi_byte, spi_byte);
                        fail_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last mismatch: expected %0d, actual %0d", want.last, last);
                        fail_count++;
                    end
                end
            end

            // watchdog on cycles without any transfer
            if (px_accepted || (pop && !empty) || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Phase sequencer
    initial
    begin : run_phases
        logic [BRIGHT_W-1:0] level;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset brightness: extremes and single channels
        add_pixel(8'h00, 8'h00, 8'h00);
        add_pixel(8'hFF, 8'hFF, 8'hFF);
        add_pixel(8'hFF, 8'h00, 8'h00);
        add_pixel(8'h00, 8'hFF, 8'h00);
        add_pixel(8'h00, 8'h00, 8'hFF);
        add_pixel(8'hAA, 8'h55, 8'hAA);
        add_pixel(8'h01, 8'h02, 8'h03);
        wait_drained();

        // full scale: bit patterns pass through unscaled
        write_brightness(BRIGHT_MAX);
        add_pixel(8'hFF, 8'hFF, 8'hFF);
        add_pixel(8'h00, 8'h00, 8'h00);
        add_pixel(8'h80, 8'h01, 8'hFF);
        add_pixel(8'h55, 8'hAA, 8'h55);
        add_pixel(8'h01, 8'h80, 8'h7F);
        wait_drained();

        // top of the register range saturates to full scale
        write_brightness(7'h7F);
        add_pixel(8'hFF, 8'h80, 8'h01);
        add_pixel(8'hC8, 8'h64, 8'h32);
        wait_drained();

        // zero brightness blanks everything
        write_brightness(7'd0);
        add_pixel(8'hFF, 8'hFF, 8'hFF);
        add_pixel(8'h11, 8'h22, 8'h33);
        wait_drained();

        // just above full scale
        write_brightness(BRIGHT_MAX + 7'd1);
        add_pixel(8'hFF, 8'h00, 8'hFF);
        wait_drained();

        // one percent: only large channels survive truncation
        write_brightness(7'd1);
        add_pixel(8'hFF, 8'h63, 8'h64);
        add_pixel(8'hC7, 8'hC8, 8'hFF);
        wait_drained();

        write_brightness(BRIGHT_MAX - 7'd1);
        add_pixel(8'hFF, 8'h65, 8'h03);
        wait_drained();

        // random pixels over several brightness settings; last phase without idling
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0:       level = 7'($urandom_range(0, 127));
                1:       level = 7'd50;
                2:       level = 7'($urandom_range(101, 127));
                3:       level = 7'($urandom_range(1, 99));
                4:       level = BRIGHT_MAX;
                default: level = 7'($urandom_range(0, 100));
            endcase
            idle_on = (ph != RAND_PHASES - 1);
            write_brightness(level);
            for (int n = 0; n < RAND_PIXELS; n++)
                add_pixel(rand_channel(), rand_channel(), rand_channel());
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
